@@ sv/qsfd_pkg.sv @@
package qsfd_pkg;

	// output coordinate field width
	localparam int COORD_OUT_W = 12;
	localparam int SIZE_W      = 3;
	localparam int DIM_W       = 13;

	// register map, byte address is 4 * index
	typedef enum logic [1:0] {
		REG_COLUMNS  = 2'd0,
		REG_ROWS     = 2'd1,
		REG_TOP_LOG2 = 2'd2,
		REG_PARENT   = 2'd3
	} reg_idx_t;

	// reset values of the configuration registers
	localparam logic [DIM_W-1:0]  RST_COLUMNS  = 13'd512;
	localparam logic [DIM_W-1:0]  RST_ROWS     = 13'd512;
	localparam logic [SIZE_W-1:0] RST_TOP_LOG2 = 3'd4;

	// one result item
	typedef struct packed {
		logic                   block_valid;
		logic [COORD_OUT_W-1:0] block_x;
		logic [COORD_OUT_W-1:0] block_y;
		logic [SIZE_W-1:0]      block_size_log2;
		logic                   is_parent;
		logic                   image_done;
	} result_t;

endpackage

@@ sv/quadtree_split_flag_decoder.sv @@
// Quadtree split flag decoder.
// Input channel (in_valid / in_stall / split_flag): one decoded split flag per
// request, for the block at the current walk position. The walk covers the
// image in raster order of top blocks, children visited TL, TR, BL, BR.
// Output channel (out_valid / out_stall / fields): exactly one result per
// input request; block_valid tells whether a block descriptor is carried,
// image_done marks the request that finishes the image.
// An accepted request's result is registered in the output register, or in
// the skid stage while that is held. Throughput: one request per cycle while
// in_stall is low, set by the position / stack update in the walk registers.
// Stall: a one-entry skid stage behind the output register takes one more
// result while out_stall is high; in_stall rises only once the skid is full.
// Reset: registers return to 512 x 512, top size 16, leaves only; the walk
// sits at the origin and both result stages are empty. Any register write
// through the APB port also restarts the walk at the origin.
module quadtree_split_flag_decoder
	import qsfd_pkg::*;
#(
	parameter int MAX_LEVELS  = 8,
	parameter int COORD_WIDTH = 12
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// configuration
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [3:0]             paddr,
	input  logic [31:0]            pwdata,
	output logic [31:0]            prdata,
	output logic                   pready,
	// split flag requests
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic                   split_flag,
	// block requests
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic                   block_valid,
	output logic [COORD_OUT_W-1:0] block_x,
	output logic [COORD_OUT_W-1:0] block_y,
	output logic [SIZE_W-1:0]      block_size_log2,
	output logic                   is_parent,
	output logic                   image_done
);

	localparam int DW   = $clog2(MAX_LEVELS + 1);
	localparam int KW   = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
	// room for a top origin plus an in-block offset of up to 127
	localparam int XW   = ((COORD_WIDTH > 7) ? COORD_WIDTH : 7) + 1;
	localparam int CMPW = (XW > DIM_W) ? XW : DIM_W;

	// configuration registers
	logic [DIM_W-1:0]  columns_q;
	logic [DIM_W-1:0]  rows_q;
	logic [SIZE_W-1:0] top_log2_q;
	logic              parent_q;

	// walk state
	logic [COORD_WIDTH-1:0] top_x_q, top_y_q;
	logic [DW-1:0]          depth_q;
	logic [1:0]             stack_q [MAX_LEVELS];

	logic [COORD_WIDTH-1:0] top_x_d, top_y_d;
	logic [DW-1:0]          depth_d;
	logic [1:0]             stack_d [MAX_LEVELS];

	// result stages
	result_t out_q, skid_q, res;
	logic    out_valid_q, skid_valid_q;

	logic cfg_wr, accept, take;

	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite;
	assign in_stall = skid_valid_q;
	assign accept   = in_valid && !in_stall;
	assign take     = out_valid_q && !out_stall;

	// register read
	always_comb begin
		unique case (reg_idx_t'(paddr[3:2]))
			REG_COLUMNS:  prdata = {19'd0, columns_q};
			REG_ROWS:     prdata = {19'd0, rows_q};
			REG_TOP_LOG2: prdata = {29'd0, top_log2_q};
			REG_PARENT:   prdata = {31'd0, parent_q};
			default:      prdata = 32'd0;
		endcase
	end

	// current block position and next walk state
	always_comb begin
		logic [XW-1:0]          off_x, off_y, pos_x, pos_y, nx, ny;
		logic [XW+COORD_OUT_W-1:0] ext_x, ext_y;
		logic [SIZE_W-1:0]      size_log2;
		logic                   can_descend, do_advance, found, done;
		logic [KW-1:0]          fk;

		off_x = '0;
		off_y = '0;
		for (int l = 1; l <= MAX_LEVELS; l++) begin
			if (l <= int'(depth_q)) begin
				off_x = off_x | (XW'(stack_q[l-1][0]) << (top_log2_q - SIZE_W'(l)));
				off_y = off_y | (XW'(stack_q[l-1][1]) << (top_log2_q - SIZE_W'(l)));
			end
		end
		pos_x     = XW'(top_x_q) + off_x;
		pos_y     = XW'(top_y_q) + off_y;
		ext_x     = {{COORD_OUT_W{1'b0}}, pos_x};
		ext_y     = {{COORD_OUT_W{1'b0}}, pos_y};
		size_log2 = SIZE_W'(int'(top_log2_q) - int'(depth_q));

		can_descend = (int'(depth_q) < int'(top_log2_q)) && (int'(depth_q) < MAX_LEVELS);
		do_advance  = !split_flag || !can_descend;

		top_x_d = top_x_q;
		top_y_d = top_y_q;
		depth_d = depth_q;
		stack_d = stack_q;
		done    = 1'b0;

		// deepest level whose child index can still step
		found = 1'b0;
		fk    = '0;
		for (int k = 0; k < MAX_LEVELS; k++) begin
			if (k < int'(depth_q) && stack_q[k] != 2'd3) begin
				found = 1'b1;
				fk    = KW'(k);
			end
		end

		nx = XW'(top_x_q) + (XW'(1) << top_log2_q);
		ny = XW'(top_y_q) + (XW'(1) << top_log2_q);

		if (!do_advance) begin
			// descend to the first child
			stack_d[depth_q[KW-1:0]] = 2'd0;
			depth_d = depth_q + DW'(1);
		end else if (found) begin
			// next sibling at that level, deeper levels clear
			for (int k = 0; k < MAX_LEVELS; k++) begin
				if (k == int'(fk)) begin
					stack_d[k] = stack_q[k] + 2'd1;
				end else if (k > int'(fk)) begin
					stack_d[k] = 2'd0;
				end
			end
			depth_d = DW'(fk) + DW'(1);
		end else begin
			// top block finished, step in raster order
			for (int k = 0; k < MAX_LEVELS; k++) begin
				stack_d[k] = 2'd0;
			end
			depth_d = '0;
			if (CMPW'(nx) < CMPW'(columns_q) && (nx >> COORD_WIDTH) == '0) begin
				top_x_d = nx[COORD_WIDTH-1:0];
			end else begin
				top_x_d = '0;
				if (CMPW'(ny) >= CMPW'(rows_q) || (ny >> COORD_WIDTH) != '0) begin
					top_y_d = '0;
					done    = 1'b1;
				end else begin
					top_y_d = ny[COORD_WIDTH-1:0];
				end
			end
		end

		// result item
		res.block_valid     = !split_flag || parent_q;
		res.is_parent       = split_flag && parent_q;
		res.image_done      = done;
		res.block_x         = res.block_valid ? ext_x[COORD_OUT_W-1:0] : '0;
		res.block_y         = res.block_valid ? ext_y[COORD_OUT_W-1:0] : '0;
		res.block_size_log2 = res.block_valid ? size_log2 : '0;
	end

	// configuration and walk state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			columns_q  <= RST_COLUMNS;
			rows_q     <= RST_ROWS;
			top_log2_q <= RST_TOP_LOG2;
			parent_q   <= 1'b0;
			top_x_q    <= '0;
			top_y_q    <= '0;
			depth_q    <= '0;
			for (int k = 0; k < MAX_LEVELS; k++) begin
				stack_q[k] <= 2'd0;
			end
		end else if (cfg_wr) begin
			unique case (reg_idx_t'(paddr[3:2]))
				REG_COLUMNS:  columns_q  <= pwdata[DIM_W-1:0];
				REG_ROWS:     rows_q     <= pwdata[DIM_W-1:0];
				REG_TOP_LOG2: top_log2_q <= pwdata[SIZE_W-1:0];
				REG_PARENT:   parent_q   <= pwdata[0];
				default:      parent_q   <= parent_q;
			endcase
			top_x_q <= '0;
			top_y_q <= '0;
			depth_q <= '0;
			for (int k = 0; k < MAX_LEVELS; k++) begin
				stack_q[k] <= 2'd0;
			end
		end else if (accept) begin
			top_x_q <= top_x_d;
			top_y_q <= top_y_d;
			depth_q <= depth_d;
			stack_q <= stack_d;
		end
	end

	// output register with skid stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
			out_q        <= '0;
			skid_q       <= '0;
		end else if (!out_valid_q || take) begin
			if (skid_valid_q) begin
				out_q        <= skid_q;
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_q       <= res;
				out_valid_q <= accept;
			end
		end else if (accept) begin
			skid_q       <= res;
			skid_valid_q <= 1'b1;
		end
	end

	assign out_valid       = out_valid_q;
	assign block_valid     = out_q.block_valid;
	assign block_x         = out_q.block_x;
	assign block_y         = out_q.block_y;
	assign block_size_log2 = out_q.block_size_log2;
	assign is_parent       = out_q.is_parent;
	assign image_done      = out_q.image_done;

endmodule

@@ test/qsfd_block_checker.sv @@
module qsfd_block_checker
	import qsfd_pkg::*;
#(
	parameter int MAX_LEVELS  = 8,
	parameter int COORD_WIDTH = 12
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic                   pready,
	input  logic [3:0]             paddr,
	input  logic [31:0]            pwdata,
	input  logic                   in_valid,
	input  logic                   in_stall,
	input  logic                   split_flag,
	input  logic                   out_valid,
	input  logic                   out_stall,
	input  logic                   block_valid,
	input  logic [COORD_OUT_W-1:0] block_x,
	input  logic [COORD_OUT_W-1:0] block_y,
	input  logic [SIZE_W-1:0]      block_size_log2,
	input  logic                   is_parent,
	input  logic                   image_done,
	output int unsigned            errors,
	output int unsigned            pending
);

	timeunit 1ns;
	timeprecision 1ps;

	// shadow of the configuration registers
	int unsigned cfg_cols;
	int unsigned cfg_rows;
	int unsigned cfg_top;
	int unsigned cfg_parent;

	// shadow of the walk position
	int unsigned origin_x;
	int unsigned origin_y;
	int unsigned level;
	logic [1:0]  child_idx [MAX_LEVELS];

	result_t blocks_due [$];
	result_t got;
	result_t want;

	function automatic void rewind_walk();
		origin_x = 0;
		origin_y = 0;
		level    = 0;
		foreach (child_idx[k])
			child_idx[k] = 2'd0;
	endfunction

	// step past the finished block; returns 1 when the image wraps
	function automatic bit next_block();
		int unsigned span;
		int unsigned lim;
		int unsigned nx;
		int unsigned ny;
		while (level > 0) begin
			if (child_idx[level-1] < 2'd3) begin
				child_idx[level-1] = child_idx[level-1] + 2'd1;
				return 1'b0;
			end
			child_idx[level-1] = 2'd0;
			level--;
		end
		span = 32'd1 << cfg_top;
		lim  = 32'd1 << COORD_WIDTH;
		nx   = origin_x + span;
		if (nx < cfg_cols && nx < lim) begin
			origin_x = nx;
			return 1'b0;
		end
		origin_x = 0;
		ny = origin_y + span;
		if (ny >= cfg_rows || ny >= lim) begin
			origin_y = 0;
			return 1'b1;
		end
		origin_y = ny;
		return 1'b0;
	endfunction

	// block descriptor for one split flag, advancing the walk
	function automatic result_t predict_block(bit flag);
		result_t     r;
		int unsigned px;
		int unsigned py;
		int unsigned lvl;
		int unsigned sz;
		bit          done_now;
		r  = '0;
		px = origin_x;
		py = origin_y;
		for (lvl = 1; lvl <= level && lvl <= MAX_LEVELS; lvl++) begin
			px += int'(child_idx[lvl-1][0]) << (cfg_top - lvl);
			py += int'(child_idx[lvl-1][1]) << (cfg_top - lvl);
		end
		sz       = cfg_top - level;
		done_now = 1'b0;
		if (!flag) begin
			r.block_valid = 1'b1;
			done_now      = next_block();
		end else begin
			if (cfg_parent != 0) begin
				r.block_valid = 1'b1;
				r.is_parent   = 1'b1;
			end
			// size-1 blocks and the deepest level have no children
			if (sz > 0 && level < MAX_LEVELS) begin
				child_idx[level] = 2'd0;
				level++;
			end else begin
				done_now = next_block();
			end
		end
		if (r.block_valid) begin
			r.block_x         = px[COORD_OUT_W-1:0];
			r.block_y         = py[COORD_OUT_W-1:0];
			r.block_size_log2 = sz[SIZE_W-1:0];
		end
		r.image_done = done_now;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_cols   = RST_COLUMNS;
			cfg_rows   = RST_ROWS;
			cfg_top    = RST_TOP_LOG2;
			cfg_parent = 0;
			rewind_walk();
			blocks_due.delete();
			errors     = 0;
			pending    = 0;
		end else begin
			// register write, any register restarts the walk
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[3:2]))
					REG_COLUMNS:  cfg_cols   = pwdata[DIM_W-1:0];
					REG_ROWS:     cfg_rows   = pwdata[DIM_W-1:0];
					REG_TOP_LOG2: cfg_top    = pwdata[SIZE_W-1:0];
					REG_PARENT:   cfg_parent = pwdata[0];
				endcase
				rewind_walk();
			end
			// compare a returned block request with the oldest prediction
			if (out_valid && !out_stall) begin
				got = '{block_valid, block_x, block_y, block_size_log2, is_parent, image_done};
				if (blocks_due.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("%0t: block request with none pending: v%0b x%0d y%0d s%0d p%0b d%0b",
							$realtime, got.block_valid, got.block_x, got.block_y,
							got.block_size_log2, got.is_parent, got.image_done);
				end else begin
					want = blocks_due.pop_front();
					if (got !== want) begin
						errors++;
						if (errors <= 10)
							$display({"%0t: block mismatch: expected v%0b x%0d y%0d s%0d p%0b d%0b,",
								" got v%0b x%0d y%0d s%0d p%0b d%0b"}, $realtime,
								want.block_valid, want.block_x, want.block_y,
								want.block_size_log2, want.is_parent, want.image_done,
								got.block_valid, got.block_x, got.block_y,
								got.block_size_log2, got.is_parent, got.image_done);
					end
				end
			end
			// accepted split flag
			if (in_valid && !in_stall)
				blocks_due.push_back(predict_block(split_flag));
			pending = blocks_due.size();
		end
	end

endmodule

@@ test/quadtree_split_flag_decoder_tb.sv @@
module quadtree_split_flag_decoder_tb
	import qsfd_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned QUIET_LIMIT = 3000;
	localparam int unsigned HOLD_AT     = 1500;
	localparam int unsigned HOLD_LEN    = 80;
	localparam int unsigned DRAIN_AT    = 975;

	typedef struct {
		int unsigned cols;
		int unsigned rows;
		int unsigned top;
		int unsigned parent;
		int unsigned count;
		int unsigned split_pct;
	} phase_t;

	// image shapes for the random part
	phase_t plan [8] = '{
		'{40,   24,   3, 0, 300, 45},
		'{8191, 200,  7, 1, 250, 20},
		'{17,   5,    2, 1, 250, 50},
		'{1,    1,    0, 0, 150, 50},
		'{4096, 8191, 5, 0, 250, 55},
		'{100,  64,   6, 1, 300, 60},
		'{0,    3000, 1, 1, 200, 50},
		'{33,   0,    4, 0, 250, 40}
	};

	bit walk_reset_cfg [8] = '{1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0};
	bit walk_deep      [9] = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0};

	logic clk = 1'b0;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [3:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;
	logic in_valid;
	logic in_stall;
	logic split_flag;
	logic out_valid;
	logic out_stall;
	logic block_valid;
	logic [COORD_OUT_W-1:0] block_x;
	logic [COORD_OUT_W-1:0] block_y;
	logic [SIZE_W-1:0] block_size_log2;
	logic is_parent;
	logic image_done;

	int unsigned errors;
	int unsigned pending;
	int unsigned tx_idle_pct;
	int unsigned rx_idle_pct;
	int unsigned blocks_taken;
	int unsigned quiet_cycles;
	int unsigned hold_left;
	bit hold_done;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	quadtree_split_flag_decoder u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.pready          (pready),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.split_flag      (split_flag),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.block_valid     (block_valid),
		.block_x         (block_x),
		.block_y         (block_y),
		.block_size_log2 (block_size_log2),
		.is_parent       (is_parent),
		.image_done      (image_done)
	);

	qsfd_block_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.pready          (pready),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.split_flag      (split_flag),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.block_valid     (block_valid),
		.block_x         (block_x),
		.block_y         (block_y),
		.block_size_log2 (block_size_log2),
		.is_parent       (is_parent),
		.image_done      (image_done),
		.errors          (errors),
		.pending         (pending)
	);

	// block receiver: random stall, plus one long hold-off to back up the input
	always @(negedge clk) begin
		if (!hold_done && blocks_taken >= HOLD_AT) begin
			hold_left = HOLD_LEN;
			hold_done = 1'b1;
		end
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else begin
			out_stall <= ($urandom_range(99) < rx_idle_pct);
		end
	end

	// watchdog on cycles with no request moving on either side
	always @(posedge clk) begin
		if (out_valid && !out_stall)
			blocks_taken++;
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("[quadtree_split_flag_decoder] ERROR");
			$finish;
		end
	end

	task automatic send_flag(input bit flag);
		@(negedge clk);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid   <= 1'b1;
		split_flag <= flag;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// stop offering and let every pending block request come back
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic apb_write(input reg_idx_t idx, input int unsigned value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic load_config(input int unsigned cols, input int unsigned rows,
			input int unsigned top, input int unsigned parent);
		drain();
		apb_write(REG_COLUMNS, cols);
		apb_write(REG_ROWS, rows);
		apb_write(REG_TOP_LOG2, top);
		apb_write(REG_PARENT, parent);
	endtask

	initial begin
		int unsigned n;
		arst_n      = 1'b0;
		psel        = 1'b0;
		penable     = 1'b0;
		pwrite      = 1'b0;
		paddr       = '0;
		pwdata      = '0;
		in_valid    = 1'b0;
		split_flag  = 1'b0;
		out_stall   = 1'b0;
		tx_idle_pct = 23;
		rx_idle_pct = 81;
		hold_left   = 0;
		hold_done   = 1'b0;
		blocks_taken = 0;
		quiet_cycles = 0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		// reset shape: leaf, descent to size 1, split of a size-1 block
		foreach (walk_reset_cfg[i])
			send_flag(walk_reset_cfg[i]);

		// zero columns and rows, one-pixel tops, parents on
		load_config(0, 0, 0, 1);
		send_flag(1'b1);
		send_flag(1'b0);

		// widest settings: descend all the way from the largest top block
		load_config(8191, 1, 7, 1);
		foreach (walk_deep[i])
			send_flag(walk_deep[i]);

		// random split flags over several image shapes
		n = 0;
		foreach (plan[p]) begin
			load_config(plan[p].cols, plan[p].rows, plan[p].top, plan[p].parent);
			repeat (plan[p].count) begin
				if (n < 650) begin
					tx_idle_pct = 23;
					rx_idle_pct = 81;
				end else if (n < 1300) begin
					tx_idle_pct = 81;
					rx_idle_pct = 23;
				end else begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
				end
				if (n == DRAIN_AT)
					drain();
				send_flag($urandom_range(99) < plan[p].split_pct);
				n++;
			end
		end

		drain();
		repeat (5) @(posedge clk);
		if (errors == 0 && pending == 0) begin
			$display("[quadtree_split_flag_decoder] OK");
		end else begin
			$display("[quadtree_split_flag_decoder] ERROR");
		end
		$finish;
	end

endmodule

@@ sim.f @@
sv/qsfd_pkg.sv
sv/quadtree_split_flag_decoder.sv
test/qsfd_block_checker.sv
test/quadtree_split_flag_decoder_tb.sv
